FILE: rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared widths, types and the search result struct of the slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SEL_W      = 5;
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned DEADLINE_W = 32;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned PROFIT_W   = 52;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [SEL_W-1:0]      sel_t;
  typedef logic [PRICE_W-1:0]    price_t;
  typedef logic [DEADLINE_W-1:0] deadline_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [PROFIT_W-1:0]   profit_t;

  typedef struct packed {
    logic found;
    sel_t idx;
  } find_t;

endpackage

FILE: rtl/dsa_if.sv
// ----------------------------------------------------------------------------
// dsa_if
// Job and result channels of the slot allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsa_job_if;
  import dsa_pkg::*;

  logic      valid;
  logic      ready;
  price_t    price;
  deadline_t deadline;

  modport source (output valid, output price, output deadline, input ready);
  modport sink   (input valid, input price, input deadline, output ready);
endinterface

interface dsa_res_if;
  import dsa_pkg::*;

  logic    valid;
  logic    ready;
  logic    accepted;
  slot_t   slot;
  profit_t total;

  modport source (output valid, output accepted, output slot, output total,
                  input ready);
  modport sink   (input valid, input accepted, input slot, input total,
                  output ready);
endinterface

FILE: rtl/dsa_ram.sv
// ----------------------------------------------------------------------------
// dsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/dsa_find.sv
// ----------------------------------------------------------------------------
// dsa_find
// Highest free bit of an occupancy word below a limit position, or at it when incl_i is set.
// ----------------------------------------------------------------------------
module dsa_find (
  input  dsa_pkg::word_t free_i,
  input  dsa_pkg::sel_t  limit_i,
  input  logic           incl_i,
  output dsa_pkg::find_t hit_o
);
  import dsa_pkg::*;

  always_comb begin
    hit_o = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (free_i[i] && ((SEL_W'(i) < limit_i) || (incl_i && (SEL_W'(i) == limit_i)))) begin
        hit_o.found = 1'b1;
        hit_o.idx   = SEL_W'(i);
      end
    end
  end

endmodule

FILE: rtl/deadline_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// deadline_slot_allocator_core
// Greedy job sequencer: each job takes the latest free slot at or before its
// deadline (clipped to SLOTS, deadline zero rejected) and adds its price to
// the running profit. Occupancy lives in a tree of 32-bit words, one RAM per
// level; a set bit above the leaves marks a full subtree. A job reads all
// ancestor words of its deadline slot at once, finds the lowest level with a
// free position below the path, descends one level per cycle, then writes the
// whole path back at once. A rejected job passes S_LOAD, S_SEARCH and S_DONE;
// an accepted one descends in S_DESC from level k to the leaves, k being the
// level where the free subtree was found (0 to ceil(log2(SLOTS)/5) - 1), and
// then passes S_UPDATE and S_DONE. A result waiting at the output holds the
// next job in its last state until that result beat is taken. After reset the
// block clears the RAMs in S_CLEAR before taking jobs.
// ----------------------------------------------------------------------------
module deadline_slot_allocator_core #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dsa_job_if.sink        job_i,
  dsa_res_if.source      res_o
);
  import dsa_pkg::*;

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned LEVELS = (IDX_W + SEL_W - 1) / SEL_W;
  localparam int unsigned PW     = LEVELS * SEL_W;
  localparam int unsigned AW0    = (IDX_W > SEL_W + 1) ? IDX_W - SEL_W : 1;
  localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SEARCH,
    S_DESC,
    S_UPDATE,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [AW0-1:0]   clr_q, clr_d;
  logic             zero_q, zero_d;
  logic             acc_q, acc_d;
  price_t           price_q, price_d;
  profit_t          profit_q, profit_d;
  logic             out_valid_q, out_valid_d;
  logic             out_acc_q, out_acc_d;
  slot_t            out_slot_q, out_slot_d;
  profit_t          out_total_q, out_total_d;

  word_t            rdata [LEVELS];
  word_t            path_q [LEVELS];
  word_t            wword [LEVELS];
  logic             full [LEVELS];
  find_t            hit [LEVELS];
  logic [PW-1:0]    rd_idx;
  logic             wr_en;
  logic             desc;
  logic             search_hit;
  logic [LVL_W-1:0] hit_lvl;
  logic [LVL_W-1:0] cur_lvl;
  sel_t             sel_idx;
  deadline_t        clip;
  deadline_t        top;
  slot_t            pos_slot;

  assign desc = (state_q == S_DESC);

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    localparam int unsigned AWK = (IDX_W > SEL_W * (k + 1) + 1) ? IDX_W - SEL_W * (k + 1) : 1;

    logic [PW-1:0]  rd_shift;
    logic [PW-1:0]  wr_shift;
    logic [AWK-1:0] waddr;
    word_t          wdata;

    assign rd_shift = rd_idx >> (SEL_W * (k + 1));
    assign wr_shift = pos_q >> (SEL_W * (k + 1));
    assign waddr    = (state_q == S_CLEAR) ? clr_q[AWK-1:0] : wr_shift[AWK-1:0];
    assign wdata    = (state_q == S_CLEAR) ? '0 : wword[k];

    if (k == 0) begin : g_leaf
      assign wword[k] = path_q[k] | (word_t'(1) << pos_q[SEL_W-1:0]);
    end else begin : g_node
      assign wword[k] = path_q[k] |
                        (full[k-1] ? (word_t'(1) << pos_q[SEL_W*k +: SEL_W]) : '0);
    end
    assign full[k] = &wword[k];

    dsa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (2 ** AWK)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (rd_shift[AWK-1:0]),
      .rdata_o (rdata[k])
    );

    dsa_find u_find (
      .free_i  (~rdata[k]),
      .limit_i (desc ? '1 : pos_q[SEL_W*k +: SEL_W]),
      .incl_i  (desc || (k == 0)),
      .hit_o   (hit[k])
    );
  end

  for (genvar b = 0; b < SLOT_W; b++) begin : g_slot
    if (b < PW) begin : g_bit
      assign pos_slot[b] = pos_q[b];
    end else begin : g_pad
      assign pos_slot[b] = 1'b0;
    end
  end

  always_comb begin
    search_hit = 1'b0;
    hit_lvl    = '0;
    for (int j = LEVELS - 1; j >= 0; j--) begin
      if (hit[j].found) begin
        search_hit = 1'b1;
        hit_lvl    = LVL_W'(j);
      end
    end
  end

  assign cur_lvl = desc ? lvl_q : hit_lvl;
  assign sel_idx = hit[cur_lvl].idx;
  assign clip    = (job_i.deadline > DEADLINE_W'(SLOTS)) ? DEADLINE_W'(SLOTS) : job_i.deadline;
  assign top     = clip - DEADLINE_W'(1);

  assign job_i.ready    = (state_q == S_IDLE);
  assign res_o.valid    = out_valid_q;
  assign res_o.accepted = out_acc_q;
  assign res_o.slot     = out_slot_q;
  assign res_o.total    = out_total_q;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    zero_d      = zero_q;
    acc_d       = acc_q;
    price_d     = price_q;
    profit_d    = profit_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_slot_d  = out_slot_q;
    out_total_d = out_total_q;
    rd_idx      = pos_q;
    wr_en       = 1'b0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + AW0'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_i.valid) begin
          price_d = job_i.price;
          zero_d  = (job_i.deadline == '0);
          pos_d   = top[PW-1:0];
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_SEARCH;
      end
      S_SEARCH, S_DESC: begin
        if (!desc && (zero_q || !search_hit)) begin
          acc_d   = 1'b0;
          state_d = S_DONE;
        end else begin
          for (int j = 0; j < LEVELS; j++) begin
            if (cur_lvl == LVL_W'(j)) begin
              pos_d[SEL_W*j +: SEL_W] = sel_idx;
            end
          end
          if (cur_lvl == '0) begin
            state_d = S_UPDATE;
          end else begin
            lvl_d   = cur_lvl - LVL_W'(1);
            rd_idx  = pos_d;
            state_d = S_DESC;
          end
        end
      end
      S_UPDATE: begin
        wr_en    = 1'b1;
        profit_d = profit_q + PROFIT_W'(price_q);
        acc_d    = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          out_slot_d  = acc_q ? pos_slot : '0;
          out_total_d = profit_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      lvl_q       <= '0;
      clr_q       <= '0;
      zero_q      <= 1'b0;
      acc_q       <= 1'b0;
      profit_q    <= '0;
      out_valid_q <= 1'b0;
      out_acc_q   <= 1'b0;
      out_slot_q  <= '0;
      out_total_q <= '0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      clr_q       <= clr_d;
      zero_q      <= zero_d;
      acc_q       <= acc_d;
      profit_q    <= profit_d;
      out_valid_q <= out_valid_d;
      out_acc_q   <= out_acc_d;
      out_slot_q  <= out_slot_d;
      out_total_q <= out_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    price_q <= price_d;
    for (int j = 0; j < LEVELS; j++) begin
      if ((state_q == S_SEARCH) || (desc && (lvl_q == LVL_W'(j)))) begin
        path_q[j] <= rdata[j];
      end
    end
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_en)
    else $error("occupancy write while idle");

  a_leaf_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> !path_q[0][pos_q[SEL_W-1:0]])
    else $error("allocating a slot that is already taken");

  a_desc_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc |-> hit[lvl_q].found)
    else $error("descent into a full subtree");

  a_profit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_UPDATE) |=> $stable(profit_q))
    else $error("profit changed outside update");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat without a finished job");

endmodule
